### rtl/core/klsl_pkg.sv
// Shared constants, types and helper functions of the keyed lease slot limiter.
`timescale 1ns / 1ps

package klsl_pkg;

	localparam int ENTRIES  = 16;
	localparam int HOLDERS  = 8;
	localparam int KEY_BITS = 16;

	localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KCNT_W = $clog2(ENTRIES + 1);
	localparam int SLOT_W = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;
	localparam int CNT_W  = $clog2(HOLDERS + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int ADDR_W = (ENTRIES * HOLDERS > 1) ? $clog2(ENTRIES * HOLDERS) : 1;

	localparam logic [15:0] TTL_RESET = 16'd300;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [ENT_W-1:0]    ent_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [ADDR_W-1:0]   addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LOOKUP,
		ST_REAP_RD,
		ST_REAP_CHK,
		ST_COMMIT
	} klsl_state_t;

	typedef enum logic [2:0] {
		FIN_NONE,
		FIN_STATUS,
		FIN_UNLIM,
		FIN_FULL,
		FIN_ZERO,
		FIN_COMMIT
	} klsl_fin_t;

	typedef struct packed {
		logic      capture;
		logic      search;
		logic      open_hit;
		logic      open_new;
		logic      rd;
		logic      chk;
		klsl_fin_t fin;
	} klsl_cmd_t;

	typedef struct packed {
		logic is_rel;
		logic kv;
		logic maxp_zero;
		logic hit;
		logic room;
		logic reap_more;
		logic expired;
		logic out_busy;
	} klsl_sts_t;

	// Ring slot from a sum known to stay below twice HOLDERS.
	function automatic slot_t slot_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(HOLDERS)) ? (s - SUM_W'(HOLDERS)) : s;
		return SLOT_W'(r);
	endfunction

	function automatic addr_t stamp_addr(input ent_t e, input slot_t s);
		return ADDR_W'(e) * ADDR_W'(HOLDERS) + ADDR_W'(s);
	endfunction

endpackage

### rtl/core/klsl_req_if.sv
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps

interface klsl_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic        key_valid;
	logic [15:0] client_key;
	logic [7:0]  slot_limit;
	logic [31:0] now_seconds;

	modport source (output valid, req_type, key_valid, client_key, slot_limit, now_seconds,
		input ready);
	modport sink (input valid, req_type, key_valid, client_key, slot_limit, now_seconds,
		output ready);
endinterface

### rtl/core/klsl_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface klsl_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       acquired;
	logic       table_full;
	logic [3:0] reaped_count;
	logic [3:0] holders_after;

	modport source (output valid, status, acquired, table_full, reaped_count, holders_after,
		input ready);
	modport sink (input valid, status, acquired, table_full, reaped_count, holders_after,
		output ready);
endinterface

### rtl/core/klsl_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the TTL value.
`timescale 1ns / 1ps

interface klsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/core/keyed_lease_slot_limiter.sv
// Keyed lease slot limiter: per-key counting semaphore whose holder leases expire.
// Requests run one at a time: a new request is accepted only once the previous one has issued
//   its result. No-key, unlimited, table-full and unknown-key requests finish at lookup; the
//   others first reap expired stamps, reading one stamp at a time up to the first live stamp.
// A waiting result holds only the next completion.
// Reset: arst_n clears key count, holder counts, ring heads and handshakes; TTL = 300.
`timescale 1ns / 1ps

module keyed_lease_slot_limiter import klsl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	klsl_req_if.sink  req,
	klsl_rsp_if.source rsp,
	klsl_cfg_if.sink  cfg
);

	klsl_cmd_t cmd;
	klsl_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	klsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	klsl_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.key_valid     (req.key_valid),
		.client_key    (req.client_key),
		.slot_limit    (req.slot_limit),
		.now_seconds   (req.now_seconds),
		.cfg_we        (cfg.valid & cfg.ready),
		.cfg_data      (cfg.data),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.status        (rsp.status),
		.acquired      (rsp.acquired),
		.table_full    (rsp.table_full),
		.reaped_count  (rsp.reaped_count),
		.holders_after (rsp.holders_after)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one still in flight");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (!rsp.acquired && !rsp.table_full &&
		rsp.reaped_count == 4'd0 && rsp.holders_after == 4'd0))
		else $error("no-key result carries other fields");

	a_full_not_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.table_full) |-> (!rsp.acquired && rsp.holders_after == 4'd0))
		else $error("table-full result reports a grant or holders");

	a_holders_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (5'(rsp.holders_after) <= 5'(HOLDERS) &&
		5'(rsp.reaped_count) <= 5'(HOLDERS)))
		else $error("holder or reap count above ring depth");
`endif

endmodule

### rtl/core/klsl_dpath.sv
// Datapath: key table, holder rings, stamp memory, reap arithmetic and result register.
`timescale 1ns / 1ps

module klsl_dpath import klsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  klsl_cmd_t   cmd,
	output klsl_sts_t   sts,
	input  logic        req_type,
	input  logic        key_valid,
	input  logic [15:0] client_key,
	input  logic [7:0]  slot_limit,
	input  logic [31:0] now_seconds,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        rsp_ready,
	output logic        rsp_valid,
	output logic        status,
	output logic        acquired,
	output logic        table_full,
	output logic [3:0]  reaped_count,
	output logic [3:0]  holders_after
);

	logic              req_type_q;
	logic              key_valid_q;
	key_t              key_q;
	logic [7:0]        maxp_q;
	logic [31:0]       now_q;
	logic [15:0]       ttl_q;

	key_t              key_store_q [ENTRIES];
	logic [KCNT_W-1:0] key_cnt_q;
	cnt_t              hcnt_q [ENTRIES];
	slot_t             head_q [ENTRIES];
	logic [ENTRIES-1:0] match_q;

	ent_t              ent_q;
	cnt_t              n_q;
	cnt_t              k_q;

	logic [31:0]       stamp_mem [ENTRIES * HOLDERS];
	logic [31:0]       rd_q;

	logic              rsp_valid_q;
	logic              status_q;
	logic              acquired_q;
	logic              table_full_q;
	cnt_t              reaped_q;
	cnt_t              after_q;

	ent_t              hit_idx;
	ent_t              new_idx;
	slot_t             head_cur;
	cnt_t              cnt_live;
	cnt_t              cap;
	logic              grant;
	logic              pop;
	cnt_t              hold_new;
	slot_t             head_new;
	slot_t             rd_slot;
	slot_t             wr_slot;
	logic              mem_we;

	assign new_idx  = key_cnt_q[ENT_W-1:0];
	assign head_cur = head_q[ent_q];

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) begin
				hit_idx = ENT_W'(i);
			end
		end
	end

	// Live holders after the reap, then grant or pop.
	always_comb begin
		cnt_live = n_q - k_q;
		cap      = (maxp_q < 8'(HOLDERS)) ? CNT_W'(maxp_q) : CNT_W'(HOLDERS);
		grant    = !req_type_q && (cnt_live < cap);
		pop      = req_type_q && (cnt_live != '0);
		hold_new = req_type_q ? (cnt_live - CNT_W'(pop)) : (cnt_live + CNT_W'(grant));
		head_new = slot_wrap(SUM_W'(head_cur) + SUM_W'(k_q) + SUM_W'(pop));
		wr_slot  = slot_wrap(SUM_W'(head_cur) + SUM_W'(n_q));
		rd_slot  = slot_wrap(SUM_W'(head_cur) + SUM_W'(k_q));
		mem_we   = (cmd.fin == FIN_COMMIT) && grant;
	end

	always_comb begin
		sts.is_rel    = req_type_q;
		sts.kv        = key_valid_q;
		sts.maxp_zero = (maxp_q == '0);
		sts.hit       = |match_q;
		sts.room      = (key_cnt_q < KCNT_W'(ENTRIES));
		sts.reap_more = (k_q < n_q);
		sts.expired   = (now_q > rd_q) && ((now_q - rd_q) > {16'd0, ttl_q});
		sts.out_busy  = rsp_valid_q && !rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q  <= req_type;
			key_valid_q <= key_valid;
			key_q       <= KEY_BITS'(client_key);
			maxp_q      <= slot_limit;
			now_q       <= now_seconds;
		end
		if (cmd.search) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= (KCNT_W'(i) < key_cnt_q) && (key_store_q[i] == key_q);
			end
		end
		if (cmd.open_new) begin
			key_store_q[new_idx] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			ttl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cnt_q <= '0;
			ent_q     <= '0;
			n_q       <= '0;
			k_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				hcnt_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			if (cmd.open_hit) begin
				ent_q <= hit_idx;
				n_q   <= hcnt_q[hit_idx];
				k_q   <= '0;
			end else if (cmd.open_new) begin
				ent_q             <= new_idx;
				n_q               <= '0;
				k_q               <= '0;
				hcnt_q[new_idx]   <= '0;
				key_cnt_q         <= key_cnt_q + 1'b1;
			end
			// Advance past each expired stamp.
			if (cmd.chk && sts.expired) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.fin == FIN_COMMIT) begin
				hcnt_q[ent_q] <= hold_new;
				head_q[ent_q] <= head_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[stamp_addr(ent_q, wr_slot)] <= now_q;
		end
		if (cmd.rd) begin
			rd_q <= stamp_mem[stamp_addr(ent_q, rd_slot)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.fin != FIN_NONE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.fin)
			FIN_NONE: begin
			end
			FIN_STATUS: begin
				status_q     <= 1'b1;
				acquired_q   <= 1'b0;
				table_full_q <= 1'b0;
				reaped_q     <= '0;
				after_q      <= '0;
			end
			FIN_UNLIM: begin
				status_q     <= 1'b0;
				acquired_q   <= 1'b1;
				table_full_q <= 1'b0;
				reaped_q     <= '0;
				after_q      <= '0;
			end
			FIN_FULL: begin
				status_q     <= 1'b0;
				acquired_q   <= 1'b0;
				table_full_q <= 1'b1;
				reaped_q     <= '0;
				after_q      <= '0;
			end
			FIN_ZERO: begin
				status_q     <= 1'b0;
				acquired_q   <= 1'b0;
				table_full_q <= 1'b0;
				reaped_q     <= '0;
				after_q      <= '0;
			end
			FIN_COMMIT: begin
				status_q     <= 1'b0;
				acquired_q   <= grant;
				table_full_q <= 1'b0;
				reaped_q     <= k_q;
				after_q      <= hold_new;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign acquired      = acquired_q;
	assign table_full    = table_full_q;
	assign reaped_count  = 4'(reaped_q);
	assign holders_after = 4'(after_q);

endmodule

### rtl/core/klsl_ctrl.sv
// Controller: sequences search, key open, stamp reap and commit for one request at a time.
`timescale 1ns / 1ps

module klsl_ctrl import klsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  klsl_sts_t sts,
	output klsl_cmd_t cmd
);

	klsl_state_t state_q;
	klsl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (!sts.is_rel) begin
					if (!sts.kv || sts.maxp_zero || (!sts.hit && !sts.room)) begin
						if (!sts.out_busy) begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_REAP_RD;
					end
				end else if (sts.kv && sts.hit) begin
					state_d = ST_REAP_RD;
				end else if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_REAP_RD: begin
				state_d = sts.reap_more ? ST_REAP_CHK : ST_COMMIT;
			end
			ST_REAP_CHK: begin
				state_d = sts.expired ? ST_REAP_RD : ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.search   = 1'b0;
		cmd.open_hit = 1'b0;
		cmd.open_new = 1'b0;
		cmd.rd       = 1'b0;
		cmd.chk      = 1'b0;
		cmd.fin      = FIN_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
			end
			ST_LOOKUP: begin
				if (!sts.is_rel) begin
					if (!sts.kv) begin
						cmd.fin = sts.out_busy ? FIN_NONE : FIN_STATUS;
					end else if (sts.maxp_zero) begin
						cmd.fin = sts.out_busy ? FIN_NONE : FIN_UNLIM;
					end else if (sts.hit) begin
						cmd.open_hit = 1'b1;
					end else if (sts.room) begin
						cmd.open_new = 1'b1;
					end else begin
						cmd.fin = sts.out_busy ? FIN_NONE : FIN_FULL;
					end
				end else if (sts.kv && sts.hit) begin
					cmd.open_hit = 1'b1;
				end else begin
					// Release of a missing or unknown key: nothing to touch.
					cmd.fin = sts.out_busy ? FIN_NONE : FIN_ZERO;
				end
			end
			ST_REAP_RD: begin
				cmd.rd = sts.reap_more;
			end
			ST_REAP_CHK: begin
				cmd.chk = 1'b1;
			end
			ST_COMMIT: begin
				cmd.fin = sts.out_busy ? FIN_NONE : FIN_COMMIT;
			end
			default: begin
			end
		endcase
	end

endmodule

### test/keyed_lease_slot_limiter_tb.sv
// Self-checking testbench for the keyed lease slot limiter with directed and random stimulus.
`timescale 1ns / 1ps

module keyed_lease_slot_limiter_tb import klsl_pkg::*; ();

	typedef enum logic {
		REQ_ACQUIRE = 1'b0,
		REQ_RELEASE = 1'b1
	} lease_op_t;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NO_KEY = 1'b1;
	localparam int   KEY_POOL      = 24;
	localparam int   PHASE_ITEMS   = 130;

	typedef struct packed {
		lease_op_t   req_type;
		logic        key_valid;
		logic [15:0] client_key;
		logic [7:0]  slot_limit;
		logic [31:0] now_seconds;
	} lease_req_t;

	typedef struct packed {
		logic       status;
		logic       acquired;
		logic       table_full;
		logic [3:0] reaped_count;
		logic [3:0] holders_after;
	} lease_result_t;

	typedef struct {
		lease_req_t    rq;
		bit            typed;
		lease_result_t want;
	} plan_row_t;

	localparam lease_result_t UNTYPED = '0;

	logic clk;
	logic arst_n;

	klsl_req_if req_ch();
	klsl_rsp_if rsp_ch();
	klsl_cfg_if cfg_ch();

	keyed_lease_slot_limiter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow of the lease table
	key_t        known_keys[ENTRIES];
	int          key_total;
	int          live_cnt[ENTRIES];
	logic [31:0] lease_stamp[ENTRIES][HOLDERS];
	logic [15:0] ttl_model;

	lease_result_t expected_verdicts[$];
	int            fail_count;
	int            calm_left;
	int            n_requests, n_grants, n_full, n_reaped, n_no_key, n_settings;

	logic [15:0] key_pool[KEY_POOL];
	logic [7:0]  pool_limit[KEY_POOL];
	logic [31:0] wall_clock;

	function automatic int lookup_key(key_t k);
		for (int i = 0; i < key_total; i++)
			if (known_keys[i] == k)
				return i;
		return -1;
	endfunction

	// Drop leading expired stamps of one entry; stop at the first live stamp.
	function automatic int reclaim_expired(int e, logic [31:0] now);
		int n;
		int k;
		n = live_cnt[e];
		k = 0;
		while (k < n && now > lease_stamp[e][k] && (now - lease_stamp[e][k]) > 32'(ttl_model))
			k++;
		for (int j = 0; j + k < n; j++)
			lease_stamp[e][j] = lease_stamp[e][j + k];
		live_cnt[e] = n - k;
		return k;
	endfunction

	function automatic lease_result_t predict_lease(lease_req_t rq);
		lease_result_t res;
		int slot;
		int cap;
		res = '0;
		if (rq.req_type == REQ_ACQUIRE) begin
			if (!rq.key_valid) begin
				res.status = STATUS_NO_KEY;
			end else if (rq.slot_limit == 8'd0) begin
				res.acquired = 1'b1;
			end else begin
				slot = lookup_key(key_t'(rq.client_key));
				if (slot < 0 && key_total < ENTRIES) begin
					slot = key_total;
					known_keys[slot] = key_t'(rq.client_key);
					live_cnt[slot] = 0;
					key_total++;
				end
				if (slot < 0) begin
					res.table_full = 1'b1;
				end else begin
					cap = (int'(rq.slot_limit) < HOLDERS) ? int'(rq.slot_limit) : HOLDERS;
					res.reaped_count = 4'(reclaim_expired(slot, rq.now_seconds));
					if (live_cnt[slot] < cap) begin
						lease_stamp[slot][live_cnt[slot]] = rq.now_seconds;
						live_cnt[slot]++;
						res.acquired = 1'b1;
					end
					res.holders_after = 4'(live_cnt[slot]);
				end
			end
		end else if (rq.key_valid) begin
			slot = lookup_key(key_t'(rq.client_key));
			if (slot >= 0) begin
				res.reaped_count = 4'(reclaim_expired(slot, rq.now_seconds));
				if (live_cnt[slot] > 0) begin
					for (int j = 0; j + 1 < live_cnt[slot]; j++)
						lease_stamp[slot][j] = lease_stamp[slot][j + 1];
					live_cnt[slot]--;
				end
				res.holders_after = 4'(live_cnt[slot]);
			end
		end
		return res;
	endfunction

	function automatic plan_row_t mk_row(lease_op_t op, logic kv, logic [15:0] key,
			logic [7:0] maxp, logic [31:0] now, bit typed, lease_result_t want);
		plan_row_t r;
		r.rq.req_type     = op;
		r.rq.key_valid    = kv;
		r.rq.client_key   = key;
		r.rq.slot_limit   = maxp;
		r.rq.now_seconds  = now;
		r.typed           = typed;
		r.want            = want;
		return r;
	endfunction

	// Mostly keys of the pool with their own limit and a clock moving forward; some noise.
	function automatic lease_req_t draw_request();
		lease_req_t rq;
		int pick;
		int roll;
		rq.req_type  = ($urandom_range(0, 99) < 35) ? REQ_RELEASE : REQ_ACQUIRE;
		rq.key_valid = ($urandom_range(0, 99) < 96);
		roll = $urandom_range(0, 99);
		if (roll < 85)
			pick = $urandom_range(0, 11);
		else if (roll < 95)
			pick = $urandom_range(12, KEY_POOL - 1);
		else
			pick = -1;
		rq.client_key = (pick < 0) ? 16'($urandom) : key_pool[pick];
		roll = $urandom_range(0, 99);
		if (pick >= 0 && roll < 70)
			rq.slot_limit = pool_limit[pick];
		else if (roll < 80)
			rq.slot_limit = 8'd0;
		else
			rq.slot_limit = 8'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 65)
			wall_clock += $urandom_range(0, int'(ttl_model) / 8 + 1);
		else if (roll < 80)
			wall_clock += 32'(ttl_model) + $urandom_range(1, int'(ttl_model) / 2 + 1);
		else if (roll < 85)
			wall_clock += 32'(ttl_model);
		rq.now_seconds = (roll >= 95) ? $urandom : wall_clock;
		return rq;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic push_request(lease_req_t rq, bit typed, lease_result_t want);
		int gap;
		lease_result_t model;
		gap = (calm_left != 0) ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= rq.req_type;
		req_ch.key_valid    <= rq.key_valid;
		req_ch.client_key   <= rq.client_key;
		req_ch.slot_limit   <= rq.slot_limit;
		req_ch.now_seconds  <= rq.now_seconds;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		model = predict_lease(rq);
		expected_verdicts.push_back(typed ? want : model);
		n_requests++;
		if (calm_left != 0)
			calm_left--;
		else if ($urandom_range(0, 19) == 0)
			calm_left = $urandom_range(10, 30);
	endtask

	// Hold requests back until every result is in, then write the TTL.
	task automatic write_ttl(logic [15:0] value);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		ttl_model = value;
		n_settings++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		plan_row_t   plan[$];
		logic [15:0] ttl_plan[5];
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_ACQUIRE;
		req_ch.key_valid    = 1'b0;
		req_ch.client_key   = '0;
		req_ch.slot_limit   = '0;
		req_ch.now_seconds  = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;
		key_total  = 0;
		ttl_model  = TTL_RESET;
		fail_count = 0;
		calm_left  = 0;
		n_requests = 0;
		n_grants   = 0;
		n_full     = 0;
		n_reaped   = 0;
		n_no_key   = 0;
		n_settings = 1;
		for (int i = 0; i < ENTRIES; i++)
			live_cnt[i] = 0;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = 16'($urandom);
		for (int i = 0; i < KEY_POOL; i++)
			pool_limit[i] = 8'($urandom_range(1, 10));
		wall_clock = $urandom_range(1000, 100000);

		// keyless, unknown-key and unlimited requests, then the first grant of a new key
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b0, 16'h5A5A, 8'd3, 32'd7, 1'b1,
			{STATUS_NO_KEY, 1'b0, 1'b0, 4'd0, 4'd0}));
		plan.push_back(mk_row(REQ_RELEASE, 1'b0, 16'h0000, 8'd0, 32'd7, 1'b1,
			{STATUS_OK, 1'b0, 1'b0, 4'd0, 4'd0}));
		plan.push_back(mk_row(REQ_RELEASE, 1'b1, 16'h1234, 8'd1, 32'd7, 1'b1,
			{STATUS_OK, 1'b0, 1'b0, 4'd0, 4'd0}));
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'hFFFF, 8'd0, 32'hFFFF_FFFF, 1'b1,
			{STATUS_OK, 1'b1, 1'b0, 4'd0, 4'd0}));
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'h0000, 8'd1, 32'd0, 1'b1,
			{STATUS_OK, 1'b1, 1'b0, 4'd0, 4'd1}));
		// limit reached, lease past the TTL, release with nothing left
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'h0000, 8'd1, 32'd5, 1'b0, UNTYPED));
		plan.push_back(mk_row(REQ_RELEASE, 1'b1, 16'h0000, 8'd9, 32'd301, 1'b0, UNTYPED));
		plan.push_back(mk_row(REQ_RELEASE, 1'b1, 16'h0000, 8'd0, 32'd301, 1'b0, UNTYPED));
		// limit clamped to the holder depth, stamps at the top of time
		for (int i = 0; i < HOLDERS + 1; i++)
			plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'hFFFF, 8'd255, 32'hFFFF_FFFF,
				1'b0, UNTYPED));
		// stamps in the future never expire
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'hFFFF, 8'd255, 32'd0, 1'b0, UNTYPED));
		plan.push_back(mk_row(REQ_RELEASE, 1'b1, 16'hFFFF, 8'd1, 32'hFFFF_FFFF, 1'b0, UNTYPED));
		plan.push_back(mk_row(REQ_ACQUIRE, 1'b1, 16'hFFFF, 8'd8, 32'hFFFF_FFFF, 1'b0, UNTYPED));

		ttl_plan[0] = 16'd0;
		ttl_plan[1] = 16'hFFFF;
		ttl_plan[2] = 16'($urandom_range(1, 2000));
		ttl_plan[3] = TTL_RESET;
		ttl_plan[4] = 16'd1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			push_request(plan[i].rq, plan[i].typed, plan[i].want);

		foreach (ttl_plan[p]) begin
			write_ttl(ttl_plan[p]);
			repeat (PHASE_ITEMS)
				push_request(draw_request(), 1'b0, UNTYPED);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d requests over %0d TTL settings with %0d keys in the table:",
			n_requests, n_settings, key_total);
		$display("  %0d grants, %0d table-full denials, %0d leases reaped, %0d keyless acquires",
			n_grants, n_full, n_reaped, n_no_key);
		if (fail_count == 0)
			$display("PASS keyed_lease_slot_limiter");
		else
			$display("FAIL keyed_lease_slot_limiter");
		$finish;
	end

	initial begin : result_sink
		lease_result_t got;
		lease_result_t want;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = (calm_left != 0) ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got = {rsp_ch.status, rsp_ch.acquired, rsp_ch.table_full,
				rsp_ch.reaped_count, rsp_ch.holders_after};
			if (expected_verdicts.size() == 0) begin
				$display("%0t ns unexpected result transaction: expected none, actual %h",
					$time, got);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				check_field("status", want.status, got.status);
				check_field("acquired", want.acquired, got.acquired);
				check_field("table_full", want.table_full, got.table_full);
				check_field("reaped_count", want.reaped_count, got.reaped_count);
				check_field("holders_after", want.holders_after, got.holders_after);
			end
			n_grants += got.acquired;
			n_full   += got.table_full;
			n_reaped += got.reaped_count;
			n_no_key += (got.status == STATUS_NO_KEY);
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAIL keyed_lease_slot_limiter");
		$finish;
	end

endmodule
